// ===== rtl/iat_pkg.sv =====
// Shared types, operation codes and defaults for the indexed array table.
package iat_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [3:0] OP_GET       = 4'd0;
  localparam logic [3:0] OP_SET       = 4'd1;
  localparam logic [3:0] OP_INSERT    = 4'd2;
  localparam logic [3:0] OP_APPEND    = 4'd3;
  localparam logic [3:0] OP_DELETE    = 4'd4;
  localparam logic [3:0] OP_FIND      = 4'd5;
  localparam logic [3:0] OP_SORT_ASC  = 4'd6;
  localparam logic [3:0] OP_SORT_DESC = 4'd7;
  localparam logic [3:0] OP_CLEAR     = 4'd8;

  typedef struct packed {
    logic [3:0]         op;
    logic [4:0]         position;
    logic signed [31:0] item_value;
  } iat_req_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] read_value;
    logic [3:0]         found_position;
    logic [4:0]         entry_count;
    logic               is_empty;
    logic               is_full;
  } iat_rsp_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic load;
  } iat_cmd_t;

  typedef struct packed {
    logic long_op;
    logic walk_done;
  } iat_status_t;

endpackage

// ===== rtl/iat_ctrl.sv =====
// Controller: handshake, walk sequencing for find and sort, result slot.
module iat_ctrl import iat_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  iat_status_t status,
  output iat_cmd_t    cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign slot_free  = !out_valid_r || out_ready;
  assign in_ready   = (state_r == S_IDLE) && slot_free;
  assign cmd.accept = in_valid && in_ready;
  assign cmd.step   = (state_r == S_WALK);
  assign cmd.load   = (cmd.accept && !status.long_op) || (cmd.step && status.walk_done);
  assign out_valid  = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept && status.long_op) state_nxt = S_WALK;
      end
      S_WALK: begin
        if (status.walk_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/iat_datapath.sv =====
// Datapath: entry cells, used count, find scan, odd-even sort, result register.
module iat_datapath import iat_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  iat_req_t    in_data,
  input  iat_cmd_t    cmd,
  output iat_status_t status,
  output iat_rsp_t    out_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > 5) ? CNT_W : 5;
  localparam int WX    = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
  localparam int FW    = (CNT_W > 4) ? CNT_W : 4;

  logic [DATA_WIDTH-1:0] cells_r [DEPTH];
  logic [DATA_WIDTH-1:0] cells_nxt [DEPTH];
  logic [DATA_WIDTH-1:0] sort_cells [DEPTH];
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      walk_r, walk_nxt;
  logic                  find_r, desc_r;
  logic [DATA_WIDTH-1:0] word_r;
  iat_rsp_t              out_data_r, out_data_nxt;

  logic [WX-1:0]         word_wide, rd_wide;
  logic [DATA_WIDTH-1:0] word_in, rd_word;
  logic [CW-1:0]         pos_ext, cnt_ext, ins_p;
  logic [IDX_W-1:0]      pos_idx, ins_idx, scan_idx;
  logic                  pos_in_range, full, ok, miss, hit, sort_last;
  logic [FW-1:0]         fpos_wide;
  logic [CW-1:0]         cnt_out_wide;

  assign word_wide    = WX'(in_data.item_value);
  assign word_in      = word_wide[DATA_WIDTH-1:0];
  assign pos_ext      = CW'(in_data.position);
  assign cnt_ext      = CW'(cnt_r);
  assign pos_idx      = pos_ext[IDX_W-1:0];
  assign pos_in_range = pos_ext < cnt_ext;
  assign full         = (cnt_r == CNT_W'(DEPTH));
  assign ins_p        = (in_data.op == OP_APPEND) ? cnt_ext : pos_ext;
  assign ins_idx      = ins_p[IDX_W-1:0];

  assign scan_idx  = walk_r[IDX_W-1:0];
  assign miss      = walk_r >= cnt_r;
  assign hit       = !miss && (cells_r[scan_idx] == word_r);
  assign sort_last = ({1'b0, walk_r} + (CNT_W + 1)'(1)) >= {1'b0, cnt_r};

  assign status.long_op   = in_data.op inside {OP_FIND, OP_SORT_ASC, OP_SORT_DESC};
  assign status.walk_done = find_r ? (miss || hit) : sort_last;

  // one odd-even transposition phase over the used entries
  always_comb begin
    sort_cells = cells_r;
    for (int i = 0; i < DEPTH - 1; i++) begin
      if ((i % 2) == int'(walk_r[0]) && CW'(i + 1) < cnt_ext) begin
        if (desc_r ? ($signed(cells_r[i]) < $signed(cells_r[i+1]))
                   : ($signed(cells_r[i]) > $signed(cells_r[i+1]))) begin
          sort_cells[i]   = cells_r[i+1];
          sort_cells[i+1] = cells_r[i];
        end
      end
    end
  end

  always_comb begin
    cells_nxt = cells_r;
    cnt_nxt   = cnt_r;
    ok        = 1'b0;
    rd_word   = '0;
    if (cmd.accept) begin
      case (in_data.op)
        OP_GET: begin
          if (pos_in_range) begin
            rd_word = cells_r[pos_idx];
            ok      = 1'b1;
          end
        end
        OP_SET: begin
          if (pos_in_range) begin
            cells_nxt[pos_idx] = word_in;
            ok                 = 1'b1;
          end
        end
        OP_INSERT, OP_APPEND: begin
          if (ins_p <= cnt_ext && !full) begin
            for (int i = 1; i < DEPTH; i++) begin
              if (CW'(i) > ins_p && CW'(i) <= cnt_ext) cells_nxt[i] = cells_r[i-1];
            end
            cells_nxt[ins_idx] = word_in;
            cnt_nxt            = cnt_r + CNT_W'(1);
            ok                 = 1'b1;
          end
        end
        OP_DELETE: begin
          if (pos_in_range) begin
            rd_word = cells_r[pos_idx];
            for (int i = 0; i < DEPTH - 1; i++) begin
              if (CW'(i) >= pos_ext && CW'(i + 1) < cnt_ext) cells_nxt[i] = cells_r[i+1];
            end
            cnt_nxt = cnt_r - CNT_W'(1);
            ok      = 1'b1;
          end
        end
        OP_CLEAR: begin
          cnt_nxt = '0;
          ok      = 1'b1;
        end
        default: ok = 1'b0;
      endcase
    end else if (cmd.step) begin
      if (find_r) begin
        ok = hit;
      end else begin
        cells_nxt = sort_cells;
        ok        = 1'b1;
      end
    end
  end

  assign rd_wide      = WX'(rd_word);
  assign fpos_wide    = (cmd.step && find_r && hit) ? FW'(walk_r) : '0;
  assign cnt_out_wide = CW'(cnt_nxt);

  always_comb begin
    out_data_nxt                = out_data_r;
    out_data_nxt.ok             = ok;
    out_data_nxt.read_value     = rd_wide[31:0];
    out_data_nxt.found_position = fpos_wide[3:0];
    out_data_nxt.entry_count    = cnt_out_wide[4:0];
    out_data_nxt.is_empty       = (cnt_nxt == '0);
    out_data_nxt.is_full        = (cnt_nxt == CNT_W'(DEPTH));
  end

  always_comb begin
    walk_nxt = walk_r;
    if (cmd.accept) begin
      walk_nxt = '0;
    end else if (cmd.step) begin
      walk_nxt = walk_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cells_r <= cells_nxt;
    walk_r  <= walk_nxt;
    if (cmd.accept) begin
      find_r <= (in_data.op == OP_FIND);
      desc_r <= (in_data.op == OP_SORT_DESC);
      word_r <= word_in;
    end
    if (cmd.load) out_data_r <= out_data_nxt;
  end

  assign out_data = out_data_r;

endmodule

// ===== rtl/indexed_array_table.sv =====
// Top level of the indexed array table: bounded ordered list with shift insert/delete.
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_ready    iat_req_t  (op, position, item_value)
//  out_     output     out_valid / out_ready  iat_rsp_t  (ok, read_value, found_position,
//                                                         entry_count, is_empty, is_full)
//
// Get, set, insert, append, delete and clear finish in the accept cycle; the result
// is registered and shows in the next cycle. Find scans one entry per cycle; sort
// runs one odd-even transposition phase per cycle. One request is in work at a
// time; in_ready also needs the result slot free or being taken. rst_n is
// synchronous and clears the count and control; entries are not cleared.
module indexed_array_table import iat_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  iat_req_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output iat_rsp_t out_data
);

  iat_cmd_t    cmd;
  iat_status_t status;

  iat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  iat_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

  a_accept_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (!out_valid || out_ready))
    else $error("request accepted while result slot is held");

  a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !in_ready)
    else $error("input ready during find or sort");

  a_walk_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && !status.walk_done) |=> !out_valid)
    else $error("result shown before find or sort finished");

endmodule
